FILE: rtl/core/ccp_pkg.sv
// Shared types, widths and constants of the centred Cartesian-to-polar converter.
// Depends on nothing; every core file refers to it by scoped names.
package ccp_pkg;

    // Configuration of the design
    localparam int COORD_WIDTH   = 12;
    localparam int CORDIC_STAGES = 16;

    // Fixed field widths
    localparam int CENTRE_BITS = 11;
    localparam int MAG_W       = 17;
    localparam int ANG_W       = 16;

    // Offset magnitude bits (the centre may exceed a narrow coordinate)
    localparam int MW = (COORD_WIDTH > CENTRE_BITS) ? COORD_WIDTH : CENTRE_BITS;
    localparam int DW = MW + 1;

    // Rotator datapath: offsets scaled by 2^16, CORDIC gain and root-two headroom
    localparam int PRESCALE = 16;
    localparam int XW       = MW + PRESCALE + 4;
    localparam int ZW       = 34;
    localparam int ZMAG_W   = 32;
    localparam int PROD_W   = ZMAG_W * 2;

    // Square root: radicand is 256 * (dx^2 + dy^2)
    localparam int VW         = 2 * MW + 1 + 8;
    localparam int SQRT_STEPS = (VW + 1) / 2;
    localparam int RW         = 2 * SQRT_STEPS + 1;

    localparam int NSTEPS = (CORDIC_STAGES > SQRT_STEPS) ? CORDIC_STAGES : SQRT_STEPS;
    localparam int IDXW   = $clog2(NSTEPS);
    localparam int NPIPE  = NSTEPS + 5;

    localparam int MAG_MAX     = (2 ** MAG_W) - 1;
    localparam int ANGLE_LIMIT = 25736;

    typedef logic        [CENTRE_BITS-1:0] t_centre;
    typedef logic        [COORD_WIDTH-1:0] t_coord;
    typedef logic signed [DW-1:0]          t_diff;
    typedef logic signed [2*DW-1:0]        t_diff_sq;
    typedef logic        [2*MW-1:0]        t_sq;
    typedef logic        [2*MW:0]          t_sq_sum;
    typedef logic signed [XW-1:0]          t_xy;
    typedef logic signed [ZW-1:0]          t_ang_acc;
    typedef logic        [ZMAG_W-1:0]      t_zmag;
    typedef logic        [PROD_W-1:0]      t_prod;
    typedef logic        [RW-1:0]          t_rt;
    typedef logic        [SQRT_STEPS:0]    t_root_r;
    typedef logic        [IDXW-1:0]        t_idx;
    typedef logic        [MAG_W-1:0]       t_mag;
    typedef logic signed [ANG_W-1:0]       t_angle;
    typedef logic                          t_cfg_idx;

    localparam t_cfg_idx CFG_CENTRE_COL = 1'b0;
    localparam t_cfg_idx CFG_CENTRE_ROW = 1'b1;

    localparam t_centre CENTRE_COL_RST = t_centre'(320);
    localparam t_centre CENTRE_ROW_RST = t_centre'(240);

    // 2^32 units per full turn
    localparam t_ang_acc HALF_TURN  = t_ang_acc'(32'h8000_0000);
    localparam t_zmag    RAD_SCALE  = 32'd3373259426;
    localparam t_prod    ROUND_HALF = t_prod'(64'h0000_8000_0000_0000);

    localparam logic [31:0] ATAN_TABLE [24] = '{
        32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
        32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
        32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
        32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
        32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
        32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051
    };

    // One step of the pipeline: rotator state and square-root state
    typedef struct packed {
        t_xy      x;
        t_xy      y;
        t_ang_acc z;
        t_rt      rem;
        t_rt      root;
        logic     zero;
    } t_step;

    function automatic t_ang_acc atan_const(t_idx idx);
        return t_ang_acc'(ATAN_TABLE[idx]);
    endfunction

endpackage

FILE: rtl/core/ccp_step.sv
// One iteration: a CORDIC vectoring rotation and one root bit, each when in range.
// Depends on ccp_pkg; the top level registers its result.
module ccp_step (
    input  ccp_pkg::t_idx  i_idx,
    input  ccp_pkg::t_step i_step,
    output ccp_pkg::t_step o_step
);

    ccp_pkg::t_xy xs;
    ccp_pkg::t_xy ys;
    ccp_pkg::t_rt bit_w;
    ccp_pkg::t_rt trial;

    always_comb begin
        o_step = i_step;
        xs     = i_step.x >>> i_idx;
        ys     = i_step.y >>> i_idx;
        bit_w  = '0;
        trial  = '0;

        // Drive y toward zero, accumulating the turned angle
        if (int'(i_idx) < ccp_pkg::CORDIC_STAGES) begin
            if (!i_step.y[ccp_pkg::XW-1]) begin
                o_step.x = i_step.x + ys;
                o_step.y = i_step.y - xs;
                o_step.z = i_step.z + ccp_pkg::atan_const(i_idx);
            end else begin
                o_step.x = i_step.x - ys;
                o_step.y = i_step.y + xs;
                o_step.z = i_step.z - ccp_pkg::atan_const(i_idx);
            end
        end

        // Restoring square root, one result bit per step
        if (int'(i_idx) < ccp_pkg::SQRT_STEPS) begin
            bit_w = ccp_pkg::t_rt'(1) << (2 * (ccp_pkg::SQRT_STEPS - 1 - int'(i_idx)));
            trial = i_step.root + bit_w;
            if (i_step.rem >= trial) begin
                o_step.rem  = i_step.rem - trial;
                o_step.root = (i_step.root >> 1) + bit_w;
            end else begin
                o_step.root = i_step.root >> 1;
            end
        end
    end

endmodule

FILE: rtl/core/centred_cartesian_to_polar.sv
// Top level of the centred Cartesian-to-polar converter: input offset, rotator
// and square-root pipeline, rounding and output register. Uses ccp_pkg, ccp_step.
//
// Each transfer on the input channel carries one pixel coordinate; the block
// subtracts the programmed image centre and returns, for every item, one result
// holding the distance from the centre (1/16 pixel, rounded to nearest) and the
// angle atan2(row offset, column offset) in radians times 8192, in -pi..+pi, with
// a zero offset giving angle 0. A fully pipelined datapath takes one item per
// clock unless stalled: NSTEPS + 5 register stages (22 with the default widths),
// where NSTEPS is the larger of the CORDIC stage count and the number of root
// bits. Stages are the offset subtract, the squaring multipliers plus half-turn
// pre-rotation, the radicand sum, one CORDIC rotation and one restoring-root bit
// per step, the angle scaling multiplier, and the rounding/output register. Every
// stage has its own valid bit and loads whenever it is empty or the stage after
// it moves, so bubbles close up and a new item is taken while a finished result
// still waits at the output. The centre registers are written through the plain
// write port and should only change while the pipeline is empty.
module centred_cartesian_to_polar (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // configuration
    input  logic                  i_cfg_we,
    input  ccp_pkg::t_cfg_idx     i_cfg_idx,
    input  ccp_pkg::t_centre      i_cfg_data,
    // input channel
    input  logic                  i_valid,
    output logic                  o_ready,
    input  ccp_pkg::t_coord       i_pixel_col,
    input  ccp_pkg::t_coord       i_pixel_row,
    // output channel
    output logic                  o_valid,
    input  logic                  i_ready,
    output ccp_pkg::t_mag         o_magnitude,
    output ccp_pkg::t_angle       o_angle
);

    localparam int P_LAST = ccp_pkg::NPIPE - 1;
    localparam int P_MUL  = ccp_pkg::NSTEPS + 3;

    // Centre registers
    ccp_pkg::t_centre r_centre_col;
    ccp_pkg::t_centre r_centre_row;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_centre_col <= ccp_pkg::CENTRE_COL_RST;
            r_centre_row <= ccp_pkg::CENTRE_ROW_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                ccp_pkg::CFG_CENTRE_COL: r_centre_col <= i_cfg_data;
                ccp_pkg::CFG_CENTRE_ROW: r_centre_row <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Pipeline flow control: a stage loads when empty or when its successor loads
    logic [ccp_pkg::NPIPE-1:0] r_vld;
    logic [ccp_pkg::NPIPE-1:0] n_vld;
    logic [ccp_pkg::NPIPE-1:0] w_adv;

    assign w_adv[P_LAST] = ~r_vld[P_LAST] | i_ready;

    for (genvar k = 0; k < P_LAST; k++) begin : g_adv
        assign w_adv[k] = ~r_vld[k] | w_adv[k+1];
    end

    assign n_vld = {r_vld[ccp_pkg::NPIPE-2:0], i_valid};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= (n_vld & w_adv) | (r_vld & ~w_adv);
        end
    end

    assign o_ready = w_adv[0];
    assign o_valid = r_vld[P_LAST];

    // Stage 0: offsets from the centre
    ccp_pkg::t_diff r_dx;
    ccp_pkg::t_diff r_dy;
    ccp_pkg::t_diff n_dx;
    ccp_pkg::t_diff n_dy;

    assign n_dx = ccp_pkg::t_diff'(i_pixel_col) - ccp_pkg::t_diff'(r_centre_col);
    assign n_dy = ccp_pkg::t_diff'(i_pixel_row) - ccp_pkg::t_diff'(r_centre_row);

    always_ff @(posedge i_clk) begin
        if (w_adv[0]) begin
            r_dx <= n_dx;
            r_dy <= n_dy;
        end
    end

    // Stage 1: squares, and half-turn pre-rotation for a negative column offset
    ccp_pkg::t_diff_sq n_sqx_full;
    ccp_pkg::t_diff_sq n_sqy_full;
    ccp_pkg::t_xy      n_x0;
    ccp_pkg::t_xy      n_y0;
    ccp_pkg::t_xy      n_x1;
    ccp_pkg::t_xy      n_y1;
    ccp_pkg::t_ang_acc n_z1;
    ccp_pkg::t_sq      r_sqx;
    ccp_pkg::t_sq      r_sqy;
    ccp_pkg::t_xy      r_x1;
    ccp_pkg::t_xy      r_y1;
    ccp_pkg::t_ang_acc r_z1;
    logic              r_zero1;

    assign n_sqx_full = r_dx * r_dx;
    assign n_sqy_full = r_dy * r_dy;
    assign n_x0       = ccp_pkg::t_xy'(r_dx) <<< ccp_pkg::PRESCALE;
    assign n_y0       = ccp_pkg::t_xy'(r_dy) <<< ccp_pkg::PRESCALE;

    always_comb begin
        n_x1 = n_x0;
        n_y1 = n_y0;
        n_z1 = '0;
        if (r_dx[ccp_pkg::DW-1]) begin
            n_x1 = -n_x0;
            n_y1 = -n_y0;
            n_z1 = r_dy[ccp_pkg::DW-1] ? -ccp_pkg::HALF_TURN : ccp_pkg::HALF_TURN;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv[1]) begin
            r_sqx   <= ccp_pkg::t_sq'(n_sqx_full);
            r_sqy   <= ccp_pkg::t_sq'(n_sqy_full);
            r_x1    <= n_x1;
            r_y1    <= n_y1;
            r_z1    <= n_z1;
            r_zero1 <= (r_dx == '0) && (r_dy == '0);
        end
    end

    // Stage 2: radicand 256 * (dx^2 + dy^2); then one register per iteration
    ccp_pkg::t_step   r_step [ccp_pkg::NSTEPS+1];
    ccp_pkg::t_step   n_step [ccp_pkg::NSTEPS+1];
    ccp_pkg::t_sq_sum n_sum;

    assign n_sum = ccp_pkg::t_sq_sum'(r_sqx) + ccp_pkg::t_sq_sum'(r_sqy);

    always_comb begin
        n_step[0].x    = r_x1;
        n_step[0].y    = r_y1;
        n_step[0].z    = r_z1;
        n_step[0].rem  = ccp_pkg::t_rt'({n_sum, 8'h00});
        n_step[0].root = '0;
        n_step[0].zero = r_zero1;
    end

    always_ff @(posedge i_clk) begin
        if (w_adv[2]) begin
            r_step[0] <= n_step[0];
        end
    end

    for (genvar k = 0; k < ccp_pkg::NSTEPS; k++) begin : g_iter
        ccp_step u_step (
            .i_idx  (ccp_pkg::t_idx'(k)),
            .i_step (r_step[k]),
            .o_step (n_step[k+1])
        );

        always_ff @(posedge i_clk) begin
            if (w_adv[k+3]) begin
                r_step[k+1] <= n_step[k+1];
            end
        end
    end

    // Angle scaling multiply and magnitude rounding
    ccp_pkg::t_step    w_fin;
    ccp_pkg::t_ang_acc n_zneg;
    ccp_pkg::t_zmag    n_zabs;
    ccp_pkg::t_prod    n_prod;
    ccp_pkg::t_root_r  n_root;
    ccp_pkg::t_root_r  n_rem;
    ccp_pkg::t_prod    r_prod;
    logic              r_neg;
    logic              r_zero_m;
    ccp_pkg::t_root_r  r_mag_r;

    assign w_fin  = r_step[ccp_pkg::NSTEPS];
    assign n_zneg = -w_fin.z;
    assign n_zabs = w_fin.z[ccp_pkg::ZW-1] ? ccp_pkg::t_zmag'(n_zneg)
                                           : ccp_pkg::t_zmag'(w_fin.z);
    assign n_prod = n_zabs * ccp_pkg::RAD_SCALE;
    assign n_root = ccp_pkg::t_root_r'(w_fin.root);
    assign n_rem  = ccp_pkg::t_root_r'(w_fin.rem);

    always_ff @(posedge i_clk) begin
        if (w_adv[P_MUL]) begin
            r_prod   <= n_prod;
            r_neg    <= w_fin.z[ccp_pkg::ZW-1];
            r_zero_m <= w_fin.zero;
            // round up when the remainder passes the root
            r_mag_r  <= n_root + ccp_pkg::t_root_r'(n_rem > n_root);
        end
    end

    // Output register: round the angle, apply its sign, saturate the magnitude
    ccp_pkg::t_prod  n_rnd;
    ccp_pkg::t_angle n_ang_u;
    ccp_pkg::t_angle n_angle;
    ccp_pkg::t_mag   n_mag;
    ccp_pkg::t_mag   r_magnitude;
    ccp_pkg::t_angle r_angle;

    assign n_rnd   = r_prod + ccp_pkg::ROUND_HALF;
    assign n_ang_u = ccp_pkg::t_angle'(n_rnd[ccp_pkg::PROD_W-1 -: ccp_pkg::ANG_W]);

    always_comb begin
        priority if (r_zero_m) begin
            n_angle = '0;
        end else if (r_neg) begin
            n_angle = -n_ang_u;
        end else begin
            n_angle = n_ang_u;
        end
        n_mag = (r_mag_r > ccp_pkg::MAG_MAX) ? ccp_pkg::t_mag'(ccp_pkg::MAG_MAX)
                                             : ccp_pkg::t_mag'(r_mag_r);
    end

    always_ff @(posedge i_clk) begin
        if (w_adv[P_LAST]) begin
            r_magnitude <= n_mag;
            r_angle     <= n_angle;
        end
    end

    assign o_magnitude = r_magnitude;
    assign o_angle     = r_angle;

endmodule

FILE: rtl/core/ccp_checker.sv
// Port-level checks on the centred Cartesian-to-polar converter, bound to its top.
// Depends on ccp_pkg and the top level's port list.
module ccp_checker (
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              i_cfg_we,
    input ccp_pkg::t_cfg_idx i_cfg_idx,
    input ccp_pkg::t_centre  i_cfg_data,
    input logic              i_valid,
    input logic              o_ready,
    input ccp_pkg::t_coord   i_pixel_col,
    input ccp_pkg::t_coord   i_pixel_row,
    input logic              o_valid,
    input logic              i_ready,
    input ccp_pkg::t_mag     o_magnitude,
    input ccp_pkg::t_angle   o_angle
);

    // Hold a stalled result
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_magnitude) && $stable(o_angle))
        else $error("stalled result changed or dropped");

    // Reset empties the pipeline
    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result valid after reset");

    // Empty output stage implies the input is ready
    a_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_valid |-> o_ready)
        else $error("input stalled with empty pipeline");

    // Angle stays within -pi..+pi
    a_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_angle >= -ccp_pkg::ANGLE_LIMIT) && (o_angle <= ccp_pkg::ANGLE_LIMIT))
        else $error("angle out of range");

    // Zero offset gives zero angle
    a_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_magnitude == '0) |-> (o_angle == '0))
        else $error("zero offset with non-zero angle");

endmodule

bind centred_cartesian_to_polar ccp_checker u_ccp_checker (.*);
